[rtl/core/pfle_pkg.sv]
// Shared types and constants for the print frame link engine.
// No dependencies.
`timescale 1ns / 1ps
package pfle_pkg;
  localparam int RxBufferBytes = 64;
  localparam int ContentBytes  = 8192;
  localparam int ChunkBytes    = 100;

  localparam logic [1:0] OP_RX    = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_SLOT  = 2'd2;
  localparam logic [1:0] OP_LOAD  = 2'd3;

  localparam logic [0:0] REG_CONTENT_LENGTH = 1'd0;
  localparam logic [0:0] REG_LINE_COUNT     = 1'd1;

  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_START = 3'd1;
  localparam logic [2:0] KIND_CHUNK = 3'd2;
  localparam logic [2:0] KIND_STOP  = 3'd3;
  localparam logic [2:0] KIND_QUERY = 3'd4;

  localparam logic [2:0] ST_STOP    = 3'd0;
  localparam logic [2:0] ST_OK      = 3'd2;
  localparam logic [2:0] ST_RUNNING = 3'd3;
  localparam logic [2:0] ST_ERROR   = 3'd4;

  localparam logic [7:0] SOF_BYTE = 8'h7E;

  // Reply frame length by kind
  function automatic logic [6:0] reply_len(input logic [2:0] kind);
    case (kind)
      KIND_START: reply_len = 7'd7;
      KIND_CHUNK: reply_len = 7'(ChunkBytes + 8);
      KIND_STOP:  reply_len = 7'd6;
      KIND_QUERY: reply_len = 7'd4;
      default:    reply_len = 7'd0;
    endcase
  endfunction

  // One byte step of Modbus CRC-16 (reflected poly 0xA001)
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
    end
    crc_step = c;
  endfunction
endpackage

[rtl/core/pfle_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module pfle_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/print_frame_link_engine.sv]
// Print frame link engine top level: deframer, reply sequencer, content store.
// Depends on pfle_pkg and pfle_ram.
//
// Channel | Dir | tdata (low bit up)                     | tuser
// s_axis  | in  | data_byte[7:0], content_address[20:8]  | operation[1:0]
// m_axis  | out | tx_byte[7:0], link_status[10:8]        | tx_valid[0]   (tlast = tx_last)
// cfg     | in  | wr_en, wr_index (0 content_length, 1 line_count), wr_data[13:0]
//
// One item per cycle. Each item produces one result, registered in the output
// register or the skid register. The content byte of a chunk is read from
// the store at the edge that advances the reply index, so the store's read
// latency stays hidden; a load into the entry being read is forwarded.
// s_axis_tready drops only while the skid register holds a result, i.e. when
// m_axis has stalled with two results waiting. Reset is synchronous and needs
// no clearing pass; the store is undefined until loaded.
`timescale 1ns / 1ps
module print_frame_link_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte, content_address
  input  logic [1:0]  s_axis_tuser,   // operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // tx_byte, link_status
  output logic        m_axis_tuser,   // tx_valid
  output logic        m_axis_tlast,   // tx_last
  input  logic        wr_en,
  input  logic [0:0]  wr_index,
  input  logic [13:0] wr_data
);
  import pfle_pkg::*;

  localparam int AW = $clog2(ContentBytes);

  logic [13:0] content_length;
  logic [6:0]  line_count;
  logic [6:0]  rx_count, rx_count_next;
  logic [7:0]  rx_frame_length, rx_function, rx_parameter;
  logic [6:0]  next_line;
  logic [2:0]  status_reg, reply_kind;
  logic [6:0]  reply_line, reply_index;
  logic [15:0] crc;
  logic [19:0] line_base;   // reply_line * ChunkBytes, registered at reply start

  // Output register and skid
  logic        out_full, skid_full;
  logic [12:0] out_data, skid_data;
  logic        in_xfer;

  assign s_axis_tready = !skid_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  logic [1:0]  op;
  logic [7:0]  dat;
  logic [12:0] addr;
  assign op   = s_axis_tuser;
  assign dat  = s_axis_tdata[7:0];
  assign addr = s_axis_tdata[20:8];

  // Content store: read the byte for the next reply index
  logic        ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]  ram_rdata;
  logic [19:0] pf_pos;
  logic [6:0]  pf_idx;
  // A load into the entry being read is missed by the read; forward it
  logic        fwd;
  logic [7:0]  fwd_byte;

  assign ram_we = in_xfer && (op == OP_LOAD) && (32'(addr) < ContentBytes);

  pfle_ram #(.Width(8), .Depth(ContentBytes)) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(addr[AW-1:0]),
    .wdata(dat),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next-state logic
  logic [2:0]  kind_n, status_n;
  logic [6:0]  rline_n, ridx_n, nline_n;
  logic [15:0] crc_n;
  logic [19:0] base_n;
  logic [7:0]  flen_n, func_n, par_n;
  logic        tv, tl;
  logic [7:0]  tb, body;
  logic [6:0]  len;
  logic [7:0]  start_n;
  logic [6:0]  lp1;
  logic        busy, go_chunk, go_stop, go_query;
  logic [6:0]  chunk_line;
  logic [19:0] pos;

  // Chunk count: content_length / 100 by reciprocal multiply, exact below 16384
  assign start_n = 8'((27'(content_length) * 27'd5243) >> 19) + 8'd1;
  assign lp1     = reply_line + 7'd1;
  assign len     = reply_len(reply_kind);
  assign pos     = line_base + 20'(reply_index) - 20'd6;

  // Reply body byte at the current index
  always_comb begin
    body = 8'h00;
    if (reply_index == 7'd0) begin
      body = SOF_BYTE;
    end else if (reply_index == 7'd1) begin
      body = {1'b0, len};
    end else begin
      case (reply_kind)
        KIND_START: begin
          if (reply_index == 7'd2) body = 8'h01;
          else if (reply_index == 7'd3) body = 8'h00;
          else body = start_n;
        end
        KIND_CHUNK: begin
          if (reply_index == 7'd2) body = 8'h02;
          else if (reply_index == 7'd3) body = 8'h00;
          else if (reply_index == 7'd4) body = {1'b0, lp1};
          else if (reply_index == 7'd5) body = 8'(ChunkBytes);
          else if (pos < 20'(content_length) && pos < 20'(ContentBytes))
            body = fwd ? fwd_byte : ram_rdata;
          else body = 8'h00;
        end
        KIND_STOP:  body = (reply_index == 7'd2) ? 8'h03 : 8'h5A;
        KIND_QUERY: body = (reply_index == 7'd2) ? 8'h04 : 8'h86;
        default:    body = 8'h00;
      endcase
    end
  end

  always_comb begin
    kind_n   = reply_kind;
    rline_n  = reply_line;
    ridx_n   = reply_index;
    crc_n    = crc;
    base_n   = line_base;
    nline_n  = next_line;
    status_n = status_reg;
    rx_count_next = rx_count;
    flen_n   = rx_frame_length;
    func_n   = rx_function;
    par_n    = rx_parameter;
    tv = 1'b0; tb = 8'h00; tl = 1'b0;
    busy = (reply_kind != KIND_NONE);
    go_chunk = 1'b0; go_stop = 1'b0; go_query = 1'b0; chunk_line = 7'd0;
    if (in_xfer) begin
      case (op)
        OP_RX: begin
          if (rx_count == 7'd1) flen_n = dat;
          else if (rx_count == 7'd2) func_n = dat;
          else if (rx_count == 7'd3) par_n = dat;
          if (32'(rx_count) < RxBufferBytes - 2) rx_count_next = rx_count + 7'd1;
          if (rx_count_next == 7'd1) begin
            if (dat != SOF_BYTE) begin
              rx_count_next = 7'd0; flen_n = 8'd0; func_n = 8'd0; par_n = 8'd0;
            end
          end else if (rx_count_next <= 7'd4) begin
            if (rx_count_next == 7'd2 && (flen_n < 8'd4 || 32'(flen_n) > RxBufferBytes)) begin
              rx_count_next = 7'd0; flen_n = 8'd0; func_n = 8'd0; par_n = 8'd0;
            end
          end else if ({1'b0, rx_count_next} >= flen_n) begin
            // Act on the completed frame
            case (func_n)
              8'h01: begin
                if (par_n != 8'd0) status_n = ST_RUNNING;
                else if (!busy) begin
                  status_n = ST_RUNNING; go_chunk = 1'b1; chunk_line = 7'd0;
                  nline_n = 7'd1;
                end
              end
              8'h02: begin
                if (par_n != 8'd0) status_n = ST_ERROR;
                else if (next_line < line_count) begin
                  if (!busy) begin
                    status_n = ST_RUNNING; go_chunk = 1'b1; chunk_line = next_line;
                    nline_n = next_line + 7'd1;
                  end
                end else if (next_line == line_count) begin
                  if (!busy) begin
                    status_n = ST_RUNNING; go_stop = 1'b1;
                  end
                end else status_n = ST_RUNNING;
              end
              8'h03: status_n = ST_OK;
              8'h04: go_query = !busy;
              default: ;
            endcase
            rx_count_next = 7'd0; flen_n = 8'd0; func_n = 8'd0; par_n = 8'd0;
          end
        end
        OP_START: begin
          if (!busy) kind_n = KIND_START;
        end
        OP_SLOT: begin
          if (busy) begin
            if ({1'b0, reply_index} + ((reply_kind == KIND_QUERY) ? 8'd0 : 8'd2)
                < {1'b0, len}) begin
              tb = body; crc_n = crc_step(crc, body);
            end else if (reply_index + 7'd2 == len) tb = crc[15:8];
            else tb = crc[7:0];
            tv = 1'b1;
            ridx_n = reply_index + 7'd1;
            if (ridx_n >= len) begin
              tl = 1'b1; kind_n = KIND_NONE; ridx_n = 7'd0;
            end
          end
        end
        default: ;
      endcase
      if (go_chunk) kind_n = KIND_CHUNK;
      if (go_stop)  kind_n = KIND_STOP;
      if (go_query) kind_n = KIND_QUERY;
      if ((op == OP_START && !busy) || go_chunk || go_stop || go_query) begin
        rline_n = go_chunk ? chunk_line : 7'd0;
        ridx_n  = 7'd0;
        crc_n   = 16'hFFFF;
        base_n  = 20'(rline_n) * 20'(ChunkBytes);
      end
    end
  end

  // Read address follows the next reply index
  assign pf_idx   = ridx_n;
  assign pf_pos   = base_n + 20'(pf_idx) - 20'd6;
  assign ram_raddr = pf_pos[AW-1:0];

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      content_length <= '0; line_count <= '0;
      rx_count <= '0; rx_frame_length <= '0; rx_function <= '0; rx_parameter <= '0;
      next_line <= '0; status_reg <= ST_STOP; reply_kind <= KIND_NONE;
      reply_line <= '0; reply_index <= '0; crc <= 16'hFFFF; line_base <= '0;
      fwd <= 1'b0;
    end else begin
      if (wr_en) begin
        case (wr_index)
          REG_CONTENT_LENGTH: content_length <= wr_data;
          REG_LINE_COUNT:     line_count <= wr_data[6:0];
          default: ;
        endcase
      end
      rx_count <= rx_count_next; rx_frame_length <= flen_n;
      rx_function <= func_n; rx_parameter <= par_n;
      next_line <= nline_n; status_reg <= status_n; reply_kind <= kind_n;
      reply_line <= rline_n; reply_index <= ridx_n; crc <= crc_n; line_base <= base_n;
      fwd <= ram_we && (addr[AW-1:0] == ram_raddr);
    end
    fwd_byte <= dat;
  end

  // Output register and skid buffer
  logic [12:0] res;
  assign res = {status_n, tl, tb, tv};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0; skid_full <= 1'b0;
    end else begin
      if (!out_full || m_axis_tready) begin
        if (skid_full) begin
          out_full <= 1'b1; skid_full <= in_xfer;
        end else out_full <= in_xfer;
      end else if (in_xfer) skid_full <= 1'b1;
    end
    if (!out_full || m_axis_tready) begin
      if (skid_full) begin
        out_data <= skid_data;
        if (in_xfer) skid_data <= res;
      end else if (in_xfer) out_data <= res;
    end else if (in_xfer) skid_data <= res;
  end

  assign m_axis_tvalid = out_full;
  assign m_axis_tdata  = {5'd0, out_data[12:10], out_data[8:1]};
  assign m_axis_tuser  = out_data[0];
  assign m_axis_tlast  = out_data[9];

`ifndef SYNTHESIS
  a_skid_only_when_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_full) else $error("skid filled while output empty");
  a_idx_in_range: assert property (@(posedge clk) disable iff (rst)
    reply_kind != KIND_NONE |-> reply_index < reply_len(reply_kind))
    else $error("reply index beyond frame");
  a_idle_index: assert property (@(posedge clk) disable iff (rst)
    reply_kind == KIND_NONE |-> reply_index == 7'd0) else $error("stale reply index");
  a_rx_sat: assert property (@(posedge clk) disable iff (rst)
    32'(rx_count) <= RxBufferBytes - 2) else $error("rx count overran");
`endif
endmodule

[bench/testbench.sv]
// Self-checking bench for print_frame_link_engine: deframing, reply sequencing, CRC, status.
// Depends on pfle_pkg and the engine RTL; the scoreboard predicts every result transfer.
`timescale 1ns / 1ps
module testbench;
  import pfle_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainWait  = 20;
  localparam int FillBytes  = 300;

  // Predicts the engine's result stream from accepted items and register writes
  class link_scoreboard;
    logic [13:0] content_len;
    logic [6:0]  lines;
    logic [6:0]  rx_cnt, nxt, rline, ridx;
    logic [7:0]  rx_len, rx_fn, rx_par;
    logic [2:0]  status, kind;
    logic [15:0] crc;
    logic [7:0]  store [ContentBytes];
    logic [11:0] expected_q [$];
    logic        expected_last_q [$];
    int          errors;
    int          replies;

    function void init();
      content_len = '0; lines = '0;
      rx_cnt = '0; rx_len = '0; rx_fn = '0; rx_par = '0;
      nxt = '0; status = ST_STOP; kind = KIND_NONE;
      rline = '0; ridx = '0; crc = 16'hFFFF;
      errors = 0; replies = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [13:0] val);
      if (idx == REG_CONTENT_LENGTH) content_len = val;
      else lines = val[6:0];
    endfunction

    function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      c = c ^ {8'h00, b};
      for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ 16'hA001) : (c >> 1);
      return c;
    endfunction

    function int frame_len(logic [2:0] k);
      case (k)
        KIND_START: return 7;
        KIND_CHUNK: return ChunkBytes + 8;
        KIND_STOP:  return 6;
        KIND_QUERY: return 4;
        default:    return 0;
      endcase
    endfunction

    function logic [7:0] payload(int i);
      int n;
      int pos;
      if (i == 0) return SOF_BYTE;
      if (i == 1) return 8'(frame_len(kind));
      case (kind)
        KIND_START: begin
          n = content_len / 100 + 1;
          if (i == 2) return 8'h01;
          if (i == 3) return 8'(n >> 8);
          return 8'(n);
        end
        KIND_CHUNK: begin
          n = rline + 1;
          if (i == 2) return 8'h02;
          if (i == 3) return 8'(n >> 8);
          if (i == 4) return 8'(n);
          if (i == 5) return 8'(ChunkBytes);
          pos = rline * ChunkBytes + (i - 6);
          if (pos < content_len && pos < ContentBytes) return store[pos];
          return 8'h00;
        end
        KIND_STOP:  return (i == 2) ? 8'h03 : 8'h5A;
        KIND_QUERY: return (i == 2) ? 8'h04 : 8'h86;
        default:    return 8'h00;
      endcase
    endfunction

    function void begin_reply(logic [2:0] k, logic [6:0] ln);
      kind = k; rline = ln; ridx = '0; crc = 16'hFFFF;
    endfunction

    // Act on a completed request frame
    function void handle_frame();
      logic busy;
      busy = (kind != KIND_NONE);
      case (rx_fn)
        8'h01: begin
          if (rx_par != 0) status = ST_RUNNING;
          else if (!busy) begin
            status = ST_RUNNING; begin_reply(KIND_CHUNK, 7'd0); nxt = 7'd1;
          end
        end
        8'h02: begin
          if (rx_par != 0) status = ST_ERROR;
          else if (nxt < lines) begin
            if (!busy) begin
              status = ST_RUNNING; begin_reply(KIND_CHUNK, nxt); nxt = nxt + 7'd1;
            end
          end else if (nxt == lines) begin
            if (!busy) begin
              status = ST_RUNNING; begin_reply(KIND_STOP, 7'd0);
            end
          end else status = ST_RUNNING;
        end
        8'h03: status = ST_OK;
        8'h04: if (!busy) begin_reply(KIND_QUERY, 7'd0);
        default: ;
      endcase
    endfunction

    function void clear_rx();
      rx_cnt = '0; rx_len = '0; rx_fn = '0; rx_par = '0;
    endfunction

    function void take_byte(logic [7:0] d);
      if (rx_cnt == 1) rx_len = d;
      else if (rx_cnt == 2) rx_fn = d;
      else if (rx_cnt == 3) rx_par = d;
      if (rx_cnt < RxBufferBytes - 2) rx_cnt = rx_cnt + 7'd1;
      if (rx_cnt == 1) begin
        if (d != SOF_BYTE) clear_rx();
      end else if (rx_cnt <= 4) begin
        if (rx_cnt == 2 && (rx_len < 4 || rx_len > RxBufferBytes)) clear_rx();
      end else if (rx_cnt >= rx_len) begin
        handle_frame();
        clear_rx();
      end
    endfunction

    // Note one accepted input transfer and queue its expected result
    function void note(logic [1:0] op, logic [7:0] d, logic [12:0] addr);
      logic       v, last;
      logic [7:0] b;
      int         len, chk;
      v = 0; last = 0; b = 0;
      case (op)
        OP_RX:    take_byte(d);
        OP_START: if (kind == KIND_NONE) begin_reply(KIND_START, 7'd0);
        OP_SLOT: if (kind != KIND_NONE) begin
          len = frame_len(kind);
          chk = (kind == KIND_QUERY) ? 0 : 2;
          if (ridx + chk < len) begin
            b = payload(ridx); crc = crc_byte(crc, b);
          end else if (ridx + 2 == len) b = crc[15:8];
          else b = crc[7:0];
          v = 1;
          ridx = ridx + 7'd1;
          if (ridx >= len) begin
            last = 1; kind = KIND_NONE; ridx = '0; replies++;
          end
        end
        default: store[addr] = d;
      endcase
      expected_q.push_back({status, b, v});
      expected_last_q.push_back(last);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check(logic [11:0] data, logic last);
      logic [11:0] e;
      logic        el;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, actual data %h last %b", $time, data, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      el = expected_last_q.pop_front();
      if (data[0] !== e[0])
        $display("%0t: tx_valid expected %b actual %b", $time, e[0], data[0]);
      if (data[8:1] !== e[8:1])
        $display("%0t: tx_byte expected %h actual %h", $time, e[8:1], data[8:1]);
      if (data[11:9] !== e[11:9])
        $display("%0t: link status expected %0d actual %0d", $time, e[11:9], data[11:9]);
      if (last !== el)
        $display("%0t: tx_last expected %b actual %b", $time, el, last);
      if (data !== e || last !== el) errors++;
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;
  logic        wr_en;
  logic [0:0]  wr_index;
  logic [13:0] wr_data;

  link_scoreboard sb;
  int  cycles;
  int  items;
  bit  calm;

  print_frame_link_engine dut (
    .clk, .rst,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .wr_en, .wr_index, .wr_data
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Abort on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, check each transfer
  initial begin : receiver
    int hold;
    hold = 0;
    m_axis_tready = 0;
    wait (sb != null);
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check({m_axis_tdata[10:8], m_axis_tdata[7:0], m_axis_tuser}, m_axis_tlast);
      if (hold > 0) hold--;
      else if (!calm && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 18);
      m_axis_tready <= (hold == 0);
    end
  end

  // Drive one item and wait for its transfer
  task automatic send_item(logic [1:0] op, logic [7:0] d, logic [12:0] addr);
    int gap;
    if (!calm && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 18);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, addr, d};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    sb.note(op, d, addr);
    items++;
  endtask

  task automatic rx_byte(logic [7:0] d);
    send_item(OP_RX, d, 13'($urandom));
  endtask

  // Request frame: marker, length, function, parameter, padding
  task automatic send_frame(logic [7:0] fn, logic [7:0] par, int len);
    int total;
    total = (len < 5) ? 5 : len;
    rx_byte(SOF_BYTE);
    rx_byte(8'(len));
    rx_byte(fn);
    rx_byte(par);
    for (int i = 4; i < total; i++) rx_byte(8'($urandom));
  endtask

  // Clock out whatever reply is pending
  task automatic drain_reply();
    while (sb.kind != KIND_NONE) send_item(OP_SLOT, 8'($urandom), 13'($urandom));
  endtask

  // Wait for every result, let the pipeline settle, then write a register
  task automatic set_reg(logic [0:0] idx, logic [13:0] val);
    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.write_reg(idx, val);
  endtask

  task automatic random_traffic(int count);
    int stop_at;
    int pick;
    int n;
    logic [7:0] fn;
    stop_at = items + count;
    while (items < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        case ($urandom_range(0, 6))
          0: fn = 8'h01;
          1, 2, 3: fn = 8'h02;
          4: fn = 8'h03;
          5: fn = 8'h04;
          default: fn = 8'($urandom);
        endcase
        send_frame(fn, ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'h00,
                   ($urandom_range(0, 9) == 0) ? $urandom_range(4, 62)
                                              : $urandom_range(4, 9));
        // Occasionally cut a frame short
        if ($urandom_range(0, 15) == 0) begin
          rx_byte(SOF_BYTE);
          rx_byte(8'($urandom_range(4, 10)));
        end
      end else if (pick < 70) begin
        n = $urandom_range(1, 120);
        repeat (n) send_item(OP_SLOT, 8'($urandom), 13'($urandom));
      end else if (pick < 78) begin
        send_item(OP_START, 8'($urandom), 13'($urandom));
      end else if (pick < 88) begin
        send_item(OP_LOAD, 8'($urandom), 13'($urandom));
      end else begin
        // Line noise, never a frame marker
        fn = 8'($urandom);
        if (fn == SOF_BYTE) fn = 8'h00;
        rx_byte(fn);
      end
    end
    drain_reply();
  endtask

  initial begin : stimulus
    sb = new();
    sb.init();
    cycles = 0; items = 0; calm = 0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = '0;
    wr_en = 1'b0; wr_index = '0; wr_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill the head of the store; content_length never exceeds it
    for (int a = 0; a < FillBytes; a++) send_item(OP_LOAD, 8'($urandom), 13'(a));

    // Directed checks with both registers at zero
    set_reg(REG_CONTENT_LENGTH, 14'd0);
    set_reg(REG_LINE_COUNT, 14'd0);
    send_item(OP_SLOT, 8'hFF, 13'h1FFF);        // slot with nothing pending
    send_item(OP_START, 8'h00, 13'h0000);
    send_item(OP_START, 8'h00, 13'h0000);       // dropped, start still pending
    drain_reply();
    send_frame(8'h01, 8'h00, 4);                // first chunk, all zero content
    send_frame(8'h04, 8'h00, 5);                // query while busy: dropped
    drain_reply();
    send_frame(8'h04, 8'h00, 6);
    drain_reply();
    send_frame(8'h02, 8'h00, 5);                // next line above line count
    send_frame(8'h02, 8'h01, 5);                // error status
    send_frame(8'h03, 8'hFF, 5);
    send_frame(8'hFF, 8'h00, 5);                // unknown function
    rx_byte(8'h55);                             // bad start byte
    rx_byte(SOF_BYTE); rx_byte(8'd3);           // length too short
    rx_byte(SOF_BYTE); rx_byte(8'd65);          // length too long
    send_frame(8'h01, 8'h05, 62);               // nonzero parameter, longest completing length
    send_item(OP_LOAD, 8'hA5, 13'h1FFF);

    // Filled content with the most lines; later lines go out as zero
    set_reg(REG_CONTENT_LENGTH, 14'(FillBytes));
    set_reg(REG_LINE_COUNT, 14'd82);
    send_frame(8'h01, 8'h00, 5);
    drain_reply();
    random_traffic(350);

    set_reg(REG_CONTENT_LENGTH, 14'd250);
    set_reg(REG_LINE_COUNT, 14'd3);
    random_traffic(350);

    set_reg(REG_CONTENT_LENGTH, 14'($urandom_range(0, FillBytes)));
    set_reg(REG_LINE_COUNT, 14'($urandom_range(0, 82)));
    random_traffic(300);
    calm = 1;
    random_traffic(200);

    // Length past the count ceiling locks the receiver for the rest of the run
    send_frame(8'h01, 8'h00, 63);
    repeat (10) rx_byte(8'($urandom));
    send_item(OP_START, 8'h00, 13'h0000);
    drain_reply();

    s_axis_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    $display("Covered %0d items and %0d complete reply frames over four register settings.",
             items, sb.replies);
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
